@@ src/fdsu_pkg.sv @@
// ----------------------------------------------------------------------------
// fdsu_pkg
// Shared types, constants and decode tables of the Forth data stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fdsu_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int WORD_W      = 32;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int FUNC_W      = 5;
	localparam int CNT_W       = $clog2(WORD_W + 1);

	typedef logic [WORD_W-1:0] word_t;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH   = 5'd0,
		OP_POP    = 5'd1,
		OP_PEEK   = 5'd2,
		OP_DUP    = 5'd3,
		OP_DROP   = 5'd4,
		OP_SWAP   = 5'd5,
		OP_OVER   = 5'd6,
		OP_2DUP   = 5'd7,
		OP_2DROP  = 5'd8,
		OP_2SWAP  = 5'd9,
		OP_2OVER  = 5'd10,
		OP_ROT    = 5'd11,
		OP_ADD    = 5'd12,
		OP_SUB    = 5'd13,
		OP_MUL    = 5'd14,
		OP_DIV    = 5'd15,
		OP_DIVMOD = 5'd16,
		OP_MOD    = 5'd17
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_FEW  = 2'd1,
		ERR_OVF  = 2'd2,
		ERR_DIV0 = 2'd3
	} err_t;

	// how a cell takes its next value
	typedef enum logic [2:0] {
		SH_HOLD,
		SH_DN1,
		SH_DN2,
		SH_UP1,
		SH_UP2
	} shift_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic signed [31:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         error_code;
		logic [8:0]         depth;
		logic               is_empty_flag;
		logic               is_full_flag;
	} rsp_t;

	// operands an operation needs
	function automatic logic [2:0] op_need(logic [FUNC_W-1:0] f);
		logic [2:0] n;
		unique case (f)
			OP_PUSH:                    n = 3'd0;
			OP_POP, OP_PEEK, OP_DUP,
			OP_DROP:                    n = 3'd1;
			OP_2SWAP, OP_2OVER:         n = 3'd4;
			OP_ROT:                     n = 3'd3;
			default:                    n = 3'd2;
		endcase
		return n;
	endfunction

	// free entries an operation needs
	function automatic logic [1:0] op_grow(logic [FUNC_W-1:0] f);
		logic [1:0] g;
		unique case (f)
			OP_PUSH, OP_DUP, OP_OVER: g = 2'd1;
			OP_2DUP, OP_2OVER:        g = 2'd2;
			default:                  g = 2'd0;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

@@ src/fdsu_cell.sv @@
// ----------------------------------------------------------------------------
// fdsu_cell
// One stack entry. Takes a new value, holds, or takes a neighbor's word.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsu_cell
	import fdsu_pkg::*;
(
	input  wire logic   clk,
	input  wire shift_t shift,
	input  wire logic   load_en,
	input  wire word_t  load_val,
	input  wire word_t  above1,
	input  wire word_t  above2,
	input  wire word_t  below1,
	input  wire word_t  below2,
	output word_t       value
);

	word_t value_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (load_en) begin
			value_q <= load_val;
		end else begin
			unique case (shift)
				SH_DN1:  value_q <= above1;
				SH_DN2:  value_q <= above2;
				SH_UP1:  value_q <= below1;
				SH_UP2:  value_q <= below2;
				default: value_q <= value_q;
			endcase
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

@@ src/fdsu_divider.sv @@
// ----------------------------------------------------------------------------
// fdsu_divider
// Signed restoring divider, one quotient bit per cycle, truncating quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module fdsu_divider
	import fdsu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire word_t dividend,
	input  wire word_t divisor,
	output logic       done,
	output word_t      quotient,
	output word_t      remainder
);

	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             fin_q;
	logic             done_q;
	word_t            rem_q;
	word_t            quo_q;
	word_t            dvs_q;
	logic             qneg_q;
	logic             rneg_q;
	word_t            q_out_q;
	word_t            r_out_q;

	logic [WORD_W:0]  shifted;
	logic [WORD_W:0]  diff;

	// one trial subtract per cycle
	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// magnitudes in, quotient bits shifted in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q  <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
			qneg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			rneg_q <= dividend[WORD_W-1];
		end else if (run_q) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
		// sign fix
		if (fin_q) begin
			q_out_q <= qneg_q ? (~quo_q + 1'b1) : quo_q;
			r_out_q <= rneg_q ? (~rem_q + 1'b1) : rem_q;
		end
	end

	assign done      = done_q;
	assign quotient  = q_out_q;
	assign remainder = r_out_q;

endmodule

`default_nettype wire

@@ src/forth_data_stack_unit.sv @@
// ----------------------------------------------------------------------------
// forth_data_stack_unit
// Forth data stack held in a chain of cells, top of stack in cell 0.
// ----------------------------------------------------------------------------
//  channel  | ports                | handshake
//  ---------+----------------------+-------------------------------
//  command  | start, busy, cmd     | taken when start & !busy
//  result   | strobe, rsp          | one cycle, cannot be held off
//
//  Every operation but div, divmod and mod is done in the cycle it is
//  taken; its result word appears in the next cycle and a new command may
//  follow at once. A division with a nonzero divisor holds busy through
//  32 divider steps, the sign fix and the write-back;
//  the result word appears in the first cycle with busy low.
//  Reset clears the entry count; cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module forth_data_stack_unit
	import fdsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire cmd_t cmd,
	output logic      strobe,
	output rsp_t      rsp
);

	state_t            state_q, state_nx;
	logic [SP_W-1:0]   sp_q, sp_nx;
	logic [FUNC_W-1:0] func_q;
	rsp_t              rsp_q;
	logic              strobe_q;

	word_t             cell_val [STACK_DEPTH];
	shift_t            shift;
	logic [3:0]        ld_en;
	word_t             ld_val [4];

	logic              fire;
	logic              go_div;
	err_t              err;
	word_t             rd;
	logic              div_done;
	word_t             div_q, div_r;
	word_t             t0, t1, t2, t3;
	logic [SP_W:0]     sp_room;

	assign t0 = cell_val[0];
	assign t1 = cell_val[1];
	assign t2 = cell_val[2];
	assign t3 = cell_val[3];
	assign sp_room = {1'b0, sp_q} + (SP_W+1)'(op_grow(cmd.func));

	// command decode and write-back of division results
	always_comb begin
		shift  = SH_HOLD;
		ld_en  = '0;
		for (int i = 0; i < 4; i++) ld_val[i] = '0;
		sp_nx  = sp_q;
		err    = ERR_OK;
		rd     = '0;
		fire   = 1'b0;
		go_div = 1'b0;
		if (state_q == ST_IDLE && start) begin
			fire = 1'b1;
			if (cmd.func > OP_MOD) begin
				err = ERR_OK;
			end else if (cmd.func == OP_POP && sp_q == '0) begin
				rd  = '1;
				err = ERR_FEW;
			end else if (sp_q < SP_W'(op_need(cmd.func))) begin
				err = ERR_FEW;
			end else if (sp_room > (SP_W+1)'(STACK_DEPTH)) begin
				err = ERR_OVF;
			end else begin
				unique case (cmd.func)
					OP_PUSH: begin
						shift = SH_DN1; ld_en[0] = 1'b1; ld_val[0] = cmd.push_value;
						sp_nx = sp_q + 1'b1;
					end
					OP_POP: begin
						rd = t0; shift = SH_UP1; sp_nx = sp_q - 1'b1;
					end
					OP_PEEK: rd = t0;
					OP_DUP: begin
						shift = SH_DN1; ld_en[0] = 1'b1; ld_val[0] = t0;
						sp_nx = sp_q + 1'b1;
					end
					OP_DROP: begin
						shift = SH_UP1; sp_nx = sp_q - 1'b1;
					end
					OP_SWAP: begin
						ld_en[1:0] = 2'b11; ld_val[0] = t1; ld_val[1] = t0;
					end
					OP_OVER: begin
						shift = SH_DN1; ld_en[0] = 1'b1; ld_val[0] = t1;
						sp_nx = sp_q + 1'b1;
					end
					OP_2DUP: begin
						shift = SH_DN2; ld_en[1:0] = 2'b11;
						ld_val[0] = t0; ld_val[1] = t1;
						sp_nx = sp_q + 2'd2;
					end
					OP_2DROP: begin
						shift = SH_UP2; sp_nx = sp_q - 2'd2;
					end
					OP_2SWAP: begin
						ld_en = 4'b1111;
						ld_val[0] = t2; ld_val[1] = t3; ld_val[2] = t0; ld_val[3] = t1;
					end
					OP_2OVER: begin
						shift = SH_DN2; ld_en[1:0] = 2'b11;
						ld_val[0] = t2; ld_val[1] = t3;
						sp_nx = sp_q + 2'd2;
					end
					OP_ROT: begin
						ld_en[2:0] = 3'b111;
						ld_val[0] = t2; ld_val[1] = t0; ld_val[2] = t1;
					end
					OP_ADD, OP_SUB, OP_MUL: begin
						shift = SH_UP1; ld_en[0] = 1'b1; sp_nx = sp_q - 1'b1;
						if (cmd.func == OP_ADD)      ld_val[0] = t1 + t0;
						else if (cmd.func == OP_SUB) ld_val[0] = t1 - t0;
						else                         ld_val[0] = t1 * t0;
					end
					default: begin
						// division family
						if (t0 == '0) begin
							shift = SH_UP1; sp_nx = sp_q - 1'b1; err = ERR_DIV0;
						end else begin
							go_div = 1'b1;
							fire   = 1'b0;
						end
					end
				endcase
			end
		end else if (state_q == ST_DIV && div_done) begin
			fire = 1'b1;
			unique case (func_q)
				OP_DIV: begin
					shift = SH_UP1; ld_en[0] = 1'b1; ld_val[0] = div_q;
					sp_nx = sp_q - 1'b1;
				end
				OP_DIVMOD: begin
					ld_en[1:0] = 2'b11; ld_val[0] = div_q; ld_val[1] = div_r;
				end
				default: begin
					shift = SH_UP1; ld_en[0] = 1'b1; ld_val[0] = div_r;
					sp_nx = sp_q - 1'b1;
				end
			endcase
		end
	end

	// state machine: next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (start && go_div) state_nx = ST_DIV;
			ST_DIV:  if (div_done)        state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// state machine: outputs
	always_comb begin
		busy = (state_q == ST_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sp_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			strobe_q <= fire;
			if (fire) sp_q <= sp_nx;
		end
	end

	// result word and latched opcode
	always_ff @(posedge clk) begin
		if (go_div) func_q <= cmd.func;
		if (fire) begin
			rsp_q.read_value    <= rd;
			rsp_q.error_code    <= err;
			rsp_q.depth         <= sp_nx;
			rsp_q.is_empty_flag <= (sp_nx == '0);
			rsp_q.is_full_flag  <= (sp_nx == SP_W'(STACK_DEPTH));
		end
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	fdsu_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (go_div),
		.dividend  (t1),
		.divisor   (t0),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// chain of cells
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		word_t a1, a2, b1, b2;
		logic  le;
		word_t lv;
		if (i >= 1) begin : g_a1
			assign a1 = cell_val[i-1];
		end else begin : g_a1z
			assign a1 = '0;
		end
		if (i >= 2) begin : g_a2
			assign a2 = cell_val[i-2];
		end else begin : g_a2z
			assign a2 = '0;
		end
		if (i + 1 < STACK_DEPTH) begin : g_b1
			assign b1 = cell_val[i+1];
		end else begin : g_b1z
			assign b1 = '0;
		end
		if (i + 2 < STACK_DEPTH) begin : g_b2
			assign b2 = cell_val[i+2];
		end else begin : g_b2z
			assign b2 = '0;
		end
		if (i < 4) begin : g_ld
			assign le = ld_en[i];
			assign lv = ld_val[i];
		end else begin : g_nold
			assign le = 1'b0;
			assign lv = '0;
		end
		fdsu_cell u_cell (
			.clk      (clk),
			.shift    (shift),
			.load_en  (le),
			.load_val (lv),
			.above1   (a1),
			.above2   (a2),
			.below1   (b1),
			.below2   (b2),
			.value    (cell_val[i])
		);
	end

endmodule

`default_nettype wire
